[hw/rtl/aes_pkg.sv]
package aes_pkg;

    localparam int unsigned ROUNDS    = 10;
    localparam int unsigned KEY_WORDS = 4 * (ROUNDS + 1);

    localparam logic [1:0] CFG_KEY_HI = 2'd0;
    localparam logic [1:0] CFG_KEY_LO = 2'd1;

    typedef logic [127:0] block_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5,
        8'h30, 8'h01, 8'h67, 8'h2B, 8'hFE, 8'hD7, 8'hAB, 8'h76,
        8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
        8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0,
        8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC,
        8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
        8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A,
        8'h07, 8'h12, 8'h80, 8'hE2, 8'hEB, 8'h27, 8'hB2, 8'h75,
        8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
        8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84,
        8'h53, 8'hD1, 8'h00, 8'hED, 8'h20, 8'hFC, 8'hB1, 8'h5B,
        8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
        8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85,
        8'h45, 8'hF9, 8'h02, 8'h7F, 8'h50, 8'h3C, 8'h9F, 8'hA8,
        8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
        8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2,
        8'hCD, 8'h0C, 8'h13, 8'hEC, 8'h5F, 8'h97, 8'h44, 8'h17,
        8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88,
        8'h46, 8'hEE, 8'hB8, 8'h14, 8'hDE, 8'h5E, 8'h0B, 8'hDB,
        8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
        8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79,
        8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9,
        8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
        8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6,
        8'hE8, 8'hDD, 8'h74, 8'h1F, 8'h4B, 8'hBD, 8'h8B, 8'h8A,
        8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
        8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E,
        8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94,
        8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
        8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2D, 8'h0F, 8'hB0, 8'h54, 8'hBB, 8'h16
    };

    localparam logic [7:0] RCON [ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

[hw/rtl/aes_key_expand.sv]
// Round-key expansion: one new round key (four words) per cycle after a key
// write, held in flip-flops as eleven 128-bit round keys.
module aes_key_expand
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [63:0]           cfg_data,
    output aes_pkg::block_t       round_key [aes_pkg::ROUNDS + 1]
);

    logic [63:0]           key_hi_reg;
    logic [63:0]           key_lo_reg;
    logic                  busy_reg;
    logic [3:0]            step_reg;
    aes_pkg::block_t       rk_reg [aes_pkg::ROUNDS + 1];
    aes_pkg::block_t       rk_next;
    logic [31:0]           temp;

    // Next round key from the previous one.
    always_comb
    begin
        temp = aes_pkg::sub_word({rk_reg[step_reg - 4'd1][23:0],
                                  rk_reg[step_reg - 4'd1][31:24]})
               ^ {aes_pkg::RCON[step_reg - 4'd1], 24'h0};
        rk_next[127:96] = rk_reg[step_reg - 4'd1][127:96] ^ temp;
        rk_next[95:64]  = rk_reg[step_reg - 4'd1][95:64]  ^ rk_next[127:96];
        rk_next[63:32]  = rk_reg[step_reg - 4'd1][63:32]  ^ rk_next[95:64];
        rk_next[31:0]   = rk_reg[step_reg - 4'd1][31:0]   ^ rk_next[63:32];
    end

    // Key registers and the expansion sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
            busy_reg   <= 1'b0;
            step_reg   <= 4'd1;
        end
        else if (cfg_we && cfg_index == aes_pkg::CFG_KEY_HI)
        begin
            key_hi_reg <= cfg_data;
            busy_reg   <= 1'b1;
            step_reg   <= 4'd1;
        end
        else if (cfg_we && cfg_index == aes_pkg::CFG_KEY_LO)
        begin
            key_lo_reg <= cfg_data;
            busy_reg   <= 1'b1;
            step_reg   <= 4'd1;
        end
        else if (busy_reg)
        begin
            if (step_reg == 4'(aes_pkg::ROUNDS))
                busy_reg <= 1'b0;
            else
                step_reg <= step_reg + 4'd1;
        end
    end

    // Round-key storage.
    always_ff @(posedge clk)
    begin
        if (cfg_we && (cfg_index == aes_pkg::CFG_KEY_HI || cfg_index == aes_pkg::CFG_KEY_LO))
            rk_reg[0] <= (cfg_index == aes_pkg::CFG_KEY_HI) ? {cfg_data, key_lo_reg}
                                                            : {key_hi_reg, cfg_data};
        else if (busy_reg)
            rk_reg[step_reg] <= rk_next;
    end

    assign round_key = rk_reg;

endmodule

[hw/rtl/aes_round.sv]
// One cipher round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
module aes_round
#(
    parameter bit LAST = 1'b0
)
(
    input  aes_pkg::block_t state_in,
    input  aes_pkg::block_t round_key,
    output aes_pkg::block_t state_out
);

    logic [7:0] b   [16];
    logic [7:0] s   [16];
    logic [7:0] m   [16];
    logic [7:0] all [4];

    always_comb
    begin
        for (int i = 0; i < 16; i++)
            b[i] = state_in[127 - 8 * i -: 8];
        // Byte r + 4c is row r, column c.
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                s[r + 4 * c] = aes_pkg::SBOX[b[r + 4 * ((c + r) % 4)]];
        for (int c = 0; c < 4; c++)
        begin
            all[c] = s[4 * c] ^ s[4 * c + 1] ^ s[4 * c + 2] ^ s[4 * c + 3];
            for (int r = 0; r < 4; r++)
                m[4 * c + r] = LAST ? s[4 * c + r]
                             : s[4 * c + r] ^ all[c]
                               ^ aes_pkg::xtime(s[4 * c + r] ^ s[4 * c + (r + 1) % 4]);
        end
        for (int i = 0; i < 16; i++)
            state_out[127 - 8 * i -: 8] = m[i] ^ round_key[127 - 8 * i -: 8];
    end

endmodule

[hw/rtl/aes128_block_encrypt.sv]
// Pipeline: one register stage for the initial key add, then one stage per round; the output
// word is taken from the last stage.
// Throughput: one word per cycle; the pipeline advances whenever the output is free.
// A key write reloads the round keys, one round key per cycle.
// Reset (rst_n, asynchronous, active low) clears the valid bits and the key registers.
module aes128_block_encrypt
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // plaintext_hi, plaintext_lo
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata   // ciphertext_hi, ciphertext_lo
);

    localparam int unsigned STAGES = aes_pkg::ROUNDS + 1;

    aes_pkg::block_t round_key [aes_pkg::ROUNDS + 1];
    aes_pkg::block_t data_reg  [STAGES];
    logic            valid_reg [STAGES];
    aes_pkg::block_t round_out [aes_pkg::ROUNDS];
    logic            advance;

    aes_key_expand u_key
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .round_key (round_key)
    );

    genvar g;
    generate
        for (g = 0; g < aes_pkg::ROUNDS; g++)
        begin : g_round
            aes_round #(.LAST(g == aes_pkg::ROUNDS - 1)) u_round
            (
                .state_in  (data_reg[g]),
                .round_key (round_key[g + 1]),
                .state_out (round_out[g])
            );
        end
    endgenerate

    // The whole pipeline moves together while the last stage can drain.
    assign advance       = !valid_reg[STAGES - 1] || m_axis_tready;
    assign s_axis_tready = advance;
    assign m_axis_tvalid = valid_reg[STAGES - 1];
    assign m_axis_tdata  = {data_reg[STAGES - 1][63:0], data_reg[STAGES - 1][127:64]};

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STAGES; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < STAGES; i++)
                valid_reg[i] <= valid_reg[i - 1];
        end
    end

    // Data stages.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg[0] <= {s_axis_tdata[63:0], s_axis_tdata[127:64]} ^ round_key[0];
            for (int i = 1; i < STAGES; i++)
                data_reg[i] <= round_out[i - 1];
        end
    end

endmodule
